### rtl/pdtz_pkg.sv
// Shared constants, types and codes for the paged decay trend block.
// No dependencies; imported by every module of the block but the checker pdtz_chk.
`timescale 1ns / 1ps
package pdtz_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int COEF_BITS    = 16;
    localparam int MAX_FADEOFFS = 64;
    localparam int TAB_LEN      = 2 * MAX_FADEOFFS;
    localparam int TAB_AW       = $clog2(TAB_LEN);

    localparam int PRICE_W = 48;
    localparam int TIME_W  = 27;
    localparam int HIST_W  = 14;
    localparam int COEF_W  = 16;
    localparam int POW_W   = COEF_BITS + 1;
    localparam int SUM_W   = 24;
    localparam int K_W     = 25;
    localparam int X_W     = PRICE_W + 1;
    localparam int NUM_W   = PRICE_W + FRAC_BITS;
    localparam int DEN_W   = PRICE_W;
    localparam int RES_W   = 64;
    localparam int OUT_W   = 32;

    localparam logic [POW_W-1:0] COEF_ONE = POW_W'(1) << COEF_BITS;
    localparam int ROUND_HALF = 1 << (COEF_BITS - 1);

    typedef logic [2:0] t_req;
    localparam t_req REQ_DEP_PRICE   = 3'd0;
    localparam t_req REQ_INDEP_PRICE = 3'd1;
    localparam t_req REQ_DEP_DEV     = 3'd2;
    localparam t_req REQ_INDEP_DEV   = 3'd3;
    localparam t_req REQ_RESET       = 3'd4;
    localparam t_req REQ_INTERRUPT   = 3'd5;
    localparam t_req REQ_RESUME      = 3'd6;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_JUMP = 2'd0;
    localparam t_mode MODE_DOWN = 2'd1;
    localparam t_mode MODE_UP   = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HISTORY   = 2'd0;
    localparam t_cfg_idx CFG_DECAY     = 2'd1;
    localparam t_cfg_idx CFG_SIGN      = 2'd2;
    localparam t_cfg_idx CFG_PORTFOLIO = 2'd3;

    localparam logic [HIST_W-1:0] HISTORY_RST = 14'd1000;
    localparam logic [COEF_W-1:0] DECAY_RST   = 16'd62259;

endpackage

### rtl/pdtz_mul.sv
// Serial shift-add multiplier: round(|x|*k / 2^16), half away from zero, signed result.
// Depends on pdtz_pkg.
`timescale 1ns / 1ps
module pdtz_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [pdtz_pkg::X_W-1:0]   i_x,
    input  logic [pdtz_pkg::K_W-1:0]          i_k,
    output logic                              o_done,
    output logic signed [pdtz_pkg::RES_W-1:0] o_res
);
    import pdtz_pkg::*;

    localparam int ACC_W = X_W + K_W;
    localparam int CNT_W = $clog2(K_W);

    logic [X_W-1:0]     r_m;
    logic [K_W-1:0]     r_k;
    logic [ACC_W-1:0]   r_acc;
    logic               r_neg;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [RES_W-1:0] r_res;

    logic [ACC_W-1:0]   n_acc;
    logic [ACC_W:0]     w_round;
    logic [RES_W-1:0]   w_mag;

    assign n_acc   = {r_acc[ACC_W-2:0], 1'b0} + (r_k[K_W-1] ? ACC_W'(r_m) : '0);
    assign w_round = {1'b0, r_acc} + (ACC_W + 1)'(ROUND_HALF);
    assign w_mag   = RES_W'(w_round[ACC_W:COEF_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_m    <= i_x[X_W-1] ? X_W'(-i_x) : X_W'(i_x);
                r_neg  <= i_x[X_W-1];
                r_k    <= i_k;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_k   <= {r_k[K_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(K_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= r_neg ? -$signed(w_mag) : $signed(w_mag);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### rtl/pdtz_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pdtz_pkg.
`timescale 1ns / 1ps
module pdtz_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pdtz_pkg::NUM_W-1:0]  i_num,
    input  logic [pdtz_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [pdtz_pkg::NUM_W-1:0]  o_quot,
    output logic [pdtz_pkg::DEN_W-1:0]  o_rem
);
    import pdtz_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_sub;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

### rtl/pdtz_tab.sv
// Decay power and prefix-sum tables, one write port, one registered read port.
// Depends on pdtz_pkg.
`timescale 1ns / 1ps
module pdtz_tab (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [pdtz_pkg::TAB_AW-1:0]  i_waddr,
    input  logic [pdtz_pkg::POW_W-1:0]   i_wpow,
    input  logic [pdtz_pkg::SUM_W-1:0]   i_wsum,
    input  logic [pdtz_pkg::TAB_AW-1:0]  i_raddr,
    output logic [pdtz_pkg::POW_W-1:0]   o_rpow,
    output logic [pdtz_pkg::SUM_W-1:0]   o_rsum
);
    import pdtz_pkg::*;

    logic [POW_W-1:0] r_pow_mem [TAB_LEN];
    logic [SUM_W-1:0] r_sum_mem [TAB_LEN];
    logic [POW_W-1:0] r_rpow;
    logic [SUM_W-1:0] r_rsum;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pow_mem[i_waddr] <= i_wpow;
            r_sum_mem[i_waddr] <= i_wsum;
        end
        r_rpow <= r_pow_mem[i_raddr];
        r_rsum <= r_sum_mem[i_raddr];
    end

    assign o_rpow = r_rpow;
    assign o_rsum = r_rsum;

endmodule

### rtl/paged_decay_trend_zscore_diff.sv
// Top level: two paged decayed averages and the z-score difference indicator.
// Depends on pdtz_pkg, pdtz_mul, pdtz_div, pdtz_tab.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready   | tdata: time_ms, price, old_price,
//          |     |                           |        reset_mode, sources_ready,
//          |     |                           |        matches_dependent; tuser: req_type
//  m       | out | o_m_tvalid / i_m_tready   | tdata: indicator; tuser: forced_zero
//  cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat at a time. The shared divider serves the page count, fadeoff count,
// page alignment and the two quotients; the shared serial multiplier serves the
// table build, the same-page update, the rounding coefficient and the three
// products of a multi-page update.
// Reset (i_rst_n low, synchronous) resets the control, configuration and tracker
// registers (not the latched beat, scratch or output data), then the tables are
// rebuilt from decay_factor, o_s_tready low meanwhile. A decay_factor write starts
// the same rebuild once the sequencer is idle. Config is always taken.
// A finished result waits in the output register; input is taken again while it
// stalls, and only the next result waits for it to drain.
`timescale 1ns / 1ps
module paged_decay_trend_zscore_diff (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [26:0] time_ms, [74:27] price, [122:75] old_price, [124:123] reset_mode,
    // [125] sources_ready, [126] matches_dependent, [127] zero
    input  logic [127:0] i_s_tdata,
    // [2:0] req_type
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] indicator
    output logic [31:0]  o_m_tdata,
    // [0] forced_zero
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import pdtz_pkg::*;

    typedef enum logic [4:0] {
        S_B0, S_B1, S_B2, S_IDLE, S_DEC, S_DEPSIDE,
        S_INIT0, S_INIT1,
        S_TR0, S_TRNW, S_TRD1, S_TRD2, S_TRS0, S_TRS1, S_TRC, S_TRM, S_TRMW, S_TRF, S_TRE,
        S_IEMIT, S_Q0, S_Q1, S_QS, S_OUT
    } t_state;

    typedef logic signed [PRICE_W-1:0] t_px;

    localparam logic [7:0]  PW_MIN  = 8'd10;
    localparam logic [7:0]  PW_MAX  = 8'd200;
    localparam logic [27:0] RECIP20 = 28'd13108;  // 2^18/20, exact for 14-bit input
    localparam logic [32:0] QCAP    = 33'h1_0000_0000;
    localparam logic signed [RES_W-1:0] MAX48 = RES_W'(64'sh0000_7FFF_FFFF_FFFF);
    localparam logic signed [RES_W-1:0] MIN48 = -RES_W'(64'sh0000_8000_0000_0000);
    localparam logic signed [34:0] MAX32 = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] MIN32 = -35'sh0_8000_0000;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    function automatic t_px sat48(input logic signed [RES_W-1:0] v);
        if (v > MAX48) return t_px'(MAX48);
        if (v < MIN48) return t_px'(MIN48);
        return t_px'(v);
    endfunction

    // ---------------- registers ----------------
    t_state r_state, n_state, r_iret, n_iret, r_tret, n_tret;

    // latched beat
    logic [2:0]        r_req, n_req;
    logic [TIME_W-1:0] r_t, n_t;
    t_px               r_price, n_price, r_oldp, n_oldp;
    logic [1:0]        r_mode, n_mode;
    logic              r_srdy, n_srdy, r_match, n_match;

    // configuration
    logic [HIST_W-1:0] r_hist, n_hist;
    logic [COEF_W-1:0] r_decay, n_decay;
    logic              r_signneg, n_signneg, r_portf, n_portf, r_rebuild, n_rebuild;

    // tracker state
    logic r_ready, n_ready, r_intr, n_intr, r_down, n_down, r_depv, n_depv, r_indv, n_indv;
    t_px  r_dep_avg, n_dep_avg, r_ind_avg, n_ind_avg;
    t_px  r_dep_cur, n_dep_cur, r_ind_cur, n_ind_cur;
    t_px  r_dep_prev, n_dep_prev, r_ind_prev, n_ind_prev;
    t_px  r_dep_dev, n_dep_dev, r_ind_dev, n_ind_dev;
    logic [TIME_W-1:0] r_pstart, n_pstart;

    // sequencer scratch
    logic              r_tsel, n_tsel, r_qsel, n_qsel;
    logic [TIME_W-1:0] r_n, n_n;
    logic [K_W-1:0]    r_c, n_c;
    logic [POW_W-1:0]  r_pown, n_pown;
    logic [1:0]        r_ph, n_ph;
    logic signed [RES_W-1:0] r_acc, n_acc;
    logic signed [33:0] r_ti, n_ti;
    logic [32:0]       r_qmag, n_qmag;
    logic              r_qneg, n_qneg;
    // finished result, moved to the output register once it is free
    logic [OUT_W-1:0]  r_pval, n_pval;
    logic              r_pforced, n_pforced;

    // table build
    logic [TAB_AW-1:0] r_bidx, n_bidx, r_taddr, n_taddr;
    logic [POW_W-1:0]  r_bpow, n_bpow;
    logic [SUM_W-1:0]  r_bsum, n_bsum;

    // shared unit requests
    logic                    r_mstart, n_mstart;
    logic signed [X_W-1:0]   r_mx, n_mx;
    logic [K_W-1:0]          r_mk, n_mk;
    logic                    r_dstart, n_dstart;
    logic [NUM_W-1:0]        r_dnum, n_dnum;
    logic [DEN_W-1:0]        r_dden, n_dden;

    // output register
    logic              r_mvalid, n_mvalid, r_oforced, n_oforced;
    logic [OUT_W-1:0]  r_oval, n_oval;

    // ---------------- units ----------------
    logic                    m_done;
    logic signed [RES_W-1:0] m_res;
    logic                    d_done;
    logic [NUM_W-1:0]        d_quot;
    logic [DEN_W-1:0]        d_rem;
    logic                    w_we;
    logic [TAB_AW-1:0]       w_waddr;
    logic [POW_W-1:0]        w_wpow, t_rpow;
    logic [SUM_W-1:0]        w_wsum, t_rsum;

    pdtz_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_x(r_mx), .i_k(r_mk), .o_done(m_done), .o_res(m_res)
    );

    pdtz_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(d_done), .o_quot(d_quot), .o_rem(d_rem)
    );

    pdtz_tab u_tab (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wpow(w_wpow), .i_wsum(w_wsum),
        .i_raddr(r_taddr), .o_rpow(t_rpow), .o_rsum(t_rsum)
    );

    // ---------------- derived values ----------------
    logic [27:0]        w_pw_prod;
    logic [9:0]         w_pw_raw;
    logic [7:0]         w_pw;
    logic [POW_W-1:0]   w_inv;
    t_px                w_cur, w_prev, w_avg;
    logic signed [27:0] w_diff;
    logic               w_near;
    logic [6:0]         w_fo;
    logic [14:0]        w_npw;
    logic signed [X_W-1:0] w_qnum;
    t_px                w_qden;
    logic [DEN_W-1:0]   w_mn, w_md;
    logic [SUM_W:0]     w_bsum_next;
    logic signed [33:0] w_qsig;
    logic signed [34:0] w_qdiff;
    logic signed [RES_W-1:0] w_jump;

    // page width = clamp(history/20, 10, 200)
    assign w_pw_prod = 28'(r_hist) * RECIP20;
    assign w_pw_raw  = w_pw_prod[27:18];
    assign w_pw      = (w_pw_raw < 10'(PW_MIN)) ? PW_MIN :
                       (w_pw_raw > 10'(PW_MAX)) ? PW_MAX : w_pw_raw[7:0];
    assign w_inv     = COEF_ONE - POW_W'(r_decay);

    assign w_cur  = r_tsel ? r_dep_cur  : r_ind_cur;
    assign w_prev = r_tsel ? r_dep_prev : r_ind_prev;
    assign w_avg  = r_tsel ? r_dep_avg  : r_ind_avg;

    // times before the page start count as inside the current page
    assign w_diff = $signed({1'b0, r_t}) - $signed({1'b0, r_pstart});
    assign w_near = w_diff < $signed({20'd0, w_pw});

    // fadeoffs = clamp(history/width, 1, MAX_FADEOFFS), from the divider result
    assign w_fo  = (d_quot == '0) ? 7'd1 :
                   (d_quot > NUM_W'(MAX_FADEOFFS)) ? 7'(MAX_FADEOFFS) : d_quot[6:0];
    assign w_npw = 15'(r_n[TAB_AW-1:0]) * 15'(w_pw);

    assign w_qnum = r_qsel ? (X_W'(r_dep_cur) - X_W'(r_dep_avg))
                           : (X_W'(r_ind_cur) - X_W'(r_ind_avg));
    assign w_qden = r_qsel ? r_dep_dev : r_ind_dev;
    assign w_mn   = w_qnum[X_W-1] ? DEN_W'(-w_qnum) : DEN_W'(w_qnum);
    assign w_md   = w_qden[PRICE_W-1] ? DEN_W'(-w_qden) : DEN_W'(w_qden);
    assign w_qsig = r_qneg ? -$signed({1'b0, r_qmag}) : $signed({1'b0, r_qmag});
    assign w_qdiff = {r_ti[33], r_ti} - {w_qsig[33], w_qsig};

    assign w_bsum_next = (SUM_W + 1)'(r_bsum) + (SUM_W + 1)'(m_res[POW_W-1:0]);
    assign w_jump = RES_W'(r_ind_avg) + RES_W'(r_price) - RES_W'(r_oldp);

    assign w_we    = (r_state == S_B0) || (r_state == S_B2 && m_done);
    assign w_waddr = (r_state == S_B0) ? '0 : r_bidx;
    assign w_wpow  = (r_state == S_B0) ? COEF_ONE : m_res[POW_W-1:0];
    assign w_wsum  = (r_state == S_B0) ? '0 :
                     (w_bsum_next > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : w_bsum_next[SUM_W-1:0];

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;  n_iret = r_iret;  n_tret = r_tret;
        n_req = r_req;  n_t = r_t;  n_price = r_price;  n_oldp = r_oldp;
        n_mode = r_mode;  n_srdy = r_srdy;  n_match = r_match;
        n_hist = r_hist;  n_decay = r_decay;  n_signneg = r_signneg;
        n_portf = r_portf;  n_rebuild = r_rebuild;
        n_ready = r_ready;  n_intr = r_intr;  n_down = r_down;
        n_depv = r_depv;  n_indv = r_indv;
        n_dep_avg = r_dep_avg;  n_ind_avg = r_ind_avg;
        n_dep_cur = r_dep_cur;  n_ind_cur = r_ind_cur;
        n_dep_prev = r_dep_prev;  n_ind_prev = r_ind_prev;
        n_dep_dev = r_dep_dev;  n_ind_dev = r_ind_dev;
        n_pstart = r_pstart;
        n_tsel = r_tsel;  n_qsel = r_qsel;  n_n = r_n;  n_c = r_c;  n_pown = r_pown;
        n_ph = r_ph;  n_acc = r_acc;  n_ti = r_ti;  n_qmag = r_qmag;  n_qneg = r_qneg;
        n_pval = r_pval;  n_pforced = r_pforced;
        n_bidx = r_bidx;  n_taddr = r_taddr;  n_bpow = r_bpow;  n_bsum = r_bsum;
        n_mstart = 1'b0;  n_mx = r_mx;  n_mk = r_mk;
        n_dstart = 1'b0;  n_dnum = r_dnum;  n_dden = r_dden;
        n_mvalid = r_mvalid && !i_m_tready;
        n_oforced = r_oforced;  n_oval = r_oval;

        unique case (r_state)
            // table build: power[i] = round(power[i-1]*d), sum[i] = sum[i-1] + power[i]
            S_B0: begin
                n_bpow  = COEF_ONE;
                n_bsum  = '0;
                n_bidx  = TAB_AW'(1);
                n_state = S_B1;
            end
            S_B1: begin
                n_mstart = 1'b1;
                n_mx     = X_W'(r_bpow);
                n_mk     = K_W'(r_decay);
                n_state  = S_B2;
            end
            S_B2: begin
                if (m_done) begin
                    n_bpow = m_res[POW_W-1:0];
                    n_bsum = w_wsum;
                    n_bidx = r_bidx + 1'b1;
                    n_state = (r_bidx == TAB_AW'(TAB_LEN - 1)) ? S_IDLE : S_B1;
                end
            end
            S_IDLE: begin
                if (r_rebuild) begin
                    n_rebuild = 1'b0;
                    n_state   = S_B0;
                end else if (i_s_tvalid) begin
                    n_req   = i_s_tuser;
                    n_t     = i_s_tdata[26:0];
                    n_price = i_s_tdata[74:27];
                    n_oldp  = i_s_tdata[122:75];
                    n_mode  = i_s_tdata[124:123];
                    n_srdy  = i_s_tdata[125];
                    n_match = i_s_tdata[126];
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                priority case (r_req)
                    REQ_DEP_PRICE: begin
                        n_dep_cur = r_price;
                        n_state   = S_DEPSIDE;
                    end
                    REQ_DEP_DEV: begin
                        n_dep_dev = r_price;
                        n_depv    = 1'b1;
                        n_state   = S_DEPSIDE;
                    end
                    REQ_INDEP_DEV: begin
                        n_ind_dev = r_price;
                        n_indv    = 1'b1;
                        n_state   = S_DEPSIDE;
                    end
                    REQ_INDEP_PRICE: begin
                        n_ind_cur = r_price;
                        if (!r_ready) begin
                            if (r_srdy) begin
                                n_ready = 1'b1;
                                n_iret  = S_IDLE;
                                n_state = S_INIT0;
                            end
                        end else begin
                            n_tsel  = 1'b0;
                            n_tret  = S_IEMIT;
                            n_state = S_TR0;
                        end
                    end
                    REQ_RESET: begin
                        if (r_mode == MODE_DOWN) begin
                            n_intr    = 1'b1;
                            n_pval    = '0;
                            n_pforced = 1'b1;
                            n_state   = S_OUT;
                        end else if (r_mode == MODE_UP) begin
                            n_intr  = 1'b0;
                            n_iret  = S_IDLE;
                            n_state = S_INIT0;
                        end else if (r_mode == MODE_JUMP) begin
                            n_ind_cur  = r_price;
                            n_ind_prev = r_price;
                            n_ind_avg  = sat48(w_jump);
                        end
                    end
                    REQ_INTERRUPT: begin
                        if (!r_portf && r_match) begin
                            n_down = 1'b1;
                            n_depv = 1'b0;
                        end
                        if (r_down || (!r_portf && r_match)) begin
                            n_intr    = 1'b1;
                            n_indv    = 1'b0;
                            n_pval    = '0;
                            n_pforced = 1'b1;
                            n_state   = S_OUT;
                        end
                    end
                    REQ_RESUME: begin
                        if (r_intr) begin
                            if (!r_portf && r_match) n_down = 1'b0;
                            if (!r_down || (!r_portf && r_match)) begin
                                n_intr  = 1'b0;
                                n_iret  = S_IDLE;
                                n_state = S_INIT0;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DEPSIDE: begin
                n_state = S_IDLE;
                if (!r_ready) begin
                    if (r_srdy) begin
                        n_ready = 1'b1;
                        n_iret  = S_IDLE;
                        n_state = S_INIT0;
                    end
                end else if (!r_intr) begin
                    n_tsel  = 1'b1;
                    n_tret  = S_IDLE;
                    n_state = S_TR0;
                end
            end
            // re-initialize: averages and previous values follow the current prices,
            // page start aligns down to a page boundary
            S_INIT0: begin
                n_dep_avg  = r_dep_cur;
                n_ind_avg  = r_ind_cur;
                n_dep_prev = r_dep_cur;
                n_ind_prev = r_ind_cur;
                n_dstart   = 1'b1;
                n_dnum     = NUM_W'(r_t);
                n_dden     = DEN_W'(w_pw);
                n_state    = S_INIT1;
            end
            S_INIT1: begin
                if (d_done) begin
                    n_pstart = r_t - TIME_W'(d_rem);
                    n_state  = r_iret;
                end
            end
            S_TR0: begin
                if (w_near) begin
                    n_mstart = 1'b1;
                    n_mx     = X_W'(w_cur) - X_W'(w_prev);
                    n_mk     = K_W'(w_inv);
                    n_state  = S_TRNW;
                end else begin
                    n_dstart = 1'b1;
                    n_dnum   = NUM_W'(w_diff[TIME_W-1:0]);
                    n_dden   = DEN_W'(w_pw);
                    n_state  = S_TRD1;
                end
            end
            S_TRNW: begin
                if (m_done) begin
                    if (r_tsel) n_dep_avg = sat48(RES_W'(w_avg) + m_res);
                    else        n_ind_avg = sat48(RES_W'(w_avg) + m_res);
                    n_state = S_TRE;
                end
            end
            S_TRD1: begin
                if (d_done) begin
                    n_n      = d_quot[TIME_W-1:0];
                    n_dstart = 1'b1;
                    n_dnum   = NUM_W'(r_hist);
                    n_dden   = DEN_W'(w_pw);
                    n_state  = S_TRD2;
                end
            end
            S_TRD2: begin
                if (d_done) begin
                    if (r_n >= TIME_W'({w_fo, 1'b0})) begin
                        // gap too long for the tables
                        n_iret  = S_TRE;
                        n_state = S_INIT0;
                    end else begin
                        n_taddr = r_n[TAB_AW-1:0] - 1'b1;
                        n_state = S_TRS0;
                    end
                end
            end
            S_TRS0: n_state = S_TRS1;
            S_TRS1: begin
                // coefficient c = round((1-d) * sum[n-1])
                n_mstart = 1'b1;
                n_mx     = X_W'(t_rsum);
                n_mk     = K_W'(w_inv);
                n_taddr  = r_n[TAB_AW-1:0];
                n_state  = S_TRC;
            end
            S_TRC: begin
                if (m_done) begin
                    n_c     = m_res[K_W-1:0];
                    n_pown  = t_rpow;
                    n_ph    = 2'd0;
                    n_acc   = '0;
                    n_state = S_TRM;
                end
            end
            S_TRM: begin
                n_mstart = 1'b1;
                unique case (r_ph)
                    2'd0: begin n_mx = X_W'(w_cur);  n_mk = K_W'(w_inv);  end
                    2'd1: begin n_mx = X_W'(w_prev); n_mk = r_c;          end
                    default: begin n_mx = X_W'(w_avg); n_mk = K_W'(r_pown); end
                endcase
                n_state = S_TRMW;
            end
            S_TRMW: begin
                if (m_done) begin
                    n_acc = r_acc + m_res;
                    if (r_ph == 2'd2) n_state = S_TRF;
                    else begin
                        n_ph    = r_ph + 1'b1;
                        n_state = S_TRM;
                    end
                end
            end
            S_TRF: begin
                if (r_tsel) n_dep_avg = sat48(r_acc);
                else        n_ind_avg = sat48(r_acc);
                n_pstart = r_pstart + TIME_W'(w_npw);
                n_state  = S_TRE;
            end
            S_TRE: begin
                if (r_tsel) n_dep_prev = r_dep_cur;
                else        n_ind_prev = r_ind_cur;
                n_state = r_tret;
            end
            S_IEMIT: begin
                n_state = S_IDLE;
                if (r_depv && r_indv) begin
                    if (r_intr) begin
                        n_pval    = '0;
                        n_pforced = 1'b1;
                        n_state   = S_OUT;
                    end else begin
                        n_qsel  = 1'b0;
                        n_state = S_Q0;
                    end
                end
            end
            // quotient = (cur - avg) / deviation, Q16, magnitude capped at 2^32
            S_Q0: begin
                n_qneg = w_qnum[X_W-1] != w_qden[PRICE_W-1];
                if (w_qden == '0) begin
                    n_qmag  = (w_mn == '0) ? '0 : QCAP;
                    n_state = S_QS;
                end else begin
                    n_dstart = 1'b1;
                    n_dnum   = {w_mn, FRAC_BITS'(0)};
                    n_dden   = w_md;
                    n_state  = S_Q1;
                end
            end
            S_Q1: begin
                if (d_done) begin
                    n_qmag  = (d_quot[NUM_W-1:32] != '0) ? QCAP : {1'b0, d_quot[31:0]};
                    n_state = S_QS;
                end
            end
            S_QS: begin
                if (!r_qsel) begin
                    n_ti    = r_signneg ? -w_qsig : w_qsig;
                    n_qsel  = 1'b1;
                    n_state = S_Q0;
                end else begin
                    n_pval    = (w_qdiff > MAX32) ? OUT_W'(MAX32) :
                                (w_qdiff < MIN32) ? OUT_W'(MIN32) : OUT_W'(w_qdiff);
                    n_pforced = 1'b0;
                    n_state   = S_OUT;
                end
            end
            // load the output register only once the previous beat has left
            S_OUT: begin
                if (!r_mvalid || i_m_tready) begin
                    n_mvalid  = 1'b1;
                    n_oval    = r_pval;
                    n_oforced = r_pforced;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HISTORY:   n_hist    = i_cfg_data[HIST_W-1:0];
                CFG_DECAY: begin
                    n_decay   = i_cfg_data;
                    n_rebuild = 1'b1;
                end
                CFG_SIGN:      n_signneg = i_cfg_data[0];
                CFG_PORTFOLIO: n_portf   = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_B0;
            r_iret    <= S_IDLE;
            r_tret    <= S_IDLE;
            r_hist    <= HISTORY_RST;
            r_decay   <= DECAY_RST;
            r_signneg <= 1'b0;
            r_portf   <= 1'b0;
            r_rebuild <= 1'b0;
            r_ready   <= 1'b0;
            r_intr    <= 1'b0;
            r_down    <= 1'b0;
            r_depv    <= 1'b0;
            r_indv    <= 1'b0;
            r_dep_avg <= '0;  r_ind_avg  <= '0;
            r_dep_cur <= '0;  r_ind_cur  <= '0;
            r_dep_prev <= '0; r_ind_prev <= '0;
            r_dep_dev <= '0;  r_ind_dev  <= '0;
            r_pstart  <= '0;
            r_mstart  <= 1'b0;
            r_dstart  <= 1'b0;
            r_mvalid  <= 1'b0;
            r_taddr   <= '0;
        end else begin
            r_state   <= n_state;
            r_iret    <= n_iret;
            r_tret    <= n_tret;
            r_hist    <= n_hist;
            r_decay   <= n_decay;
            r_signneg <= n_signneg;
            r_portf   <= n_portf;
            r_rebuild <= n_rebuild;
            r_ready   <= n_ready;
            r_intr    <= n_intr;
            r_down    <= n_down;
            r_depv    <= n_depv;
            r_indv    <= n_indv;
            r_dep_avg <= n_dep_avg;  r_ind_avg  <= n_ind_avg;
            r_dep_cur <= n_dep_cur;  r_ind_cur  <= n_ind_cur;
            r_dep_prev <= n_dep_prev; r_ind_prev <= n_ind_prev;
            r_dep_dev <= n_dep_dev;  r_ind_dev  <= n_ind_dev;
            r_pstart  <= n_pstart;
            r_mstart  <= n_mstart;
            r_dstart  <= n_dstart;
            r_mvalid  <= n_mvalid;
            r_taddr   <= n_taddr;
        end
        r_req <= n_req;  r_t <= n_t;  r_price <= n_price;  r_oldp <= n_oldp;
        r_mode <= n_mode;  r_srdy <= n_srdy;  r_match <= n_match;
        r_tsel <= n_tsel;  r_qsel <= n_qsel;  r_n <= n_n;  r_c <= n_c;  r_pown <= n_pown;
        r_ph <= n_ph;  r_acc <= n_acc;  r_ti <= n_ti;  r_qmag <= n_qmag;  r_qneg <= n_qneg;
        r_pval <= n_pval;  r_pforced <= n_pforced;
        r_bidx <= n_bidx;  r_bpow <= n_bpow;  r_bsum <= n_bsum;
        r_mx <= n_mx;  r_mk <= n_mk;  r_dnum <= n_dnum;  r_dden <= n_dden;
        r_oval <= n_oval;  r_oforced <= n_oforced;
    end

    assign o_s_tready  = (r_state == S_IDLE) && !r_rebuild;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_mvalid;
    assign o_m_tdata   = r_oval;
    assign o_m_tuser   = r_oforced;

endmodule

### rtl/pdtz_chk.sv
// Port-level checker for paged_decay_trend_zscore_diff, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module pdtz_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [127:0] i_s_tdata,
    input logic [2:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [31:0]  o_m_tdata,
    input logic [0:0]   o_m_tuser,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [1:0]   i_cfg_index,
    input logic [15:0]  i_cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // a forced result carries a zero indicator
    a_forced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("forced result with nonzero indicator");

    // one beat at a time: the sequencer is busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken on back-to-back cycles");

    // reset empties the output and stalls the input for the table build
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("output or input open right after reset");

endmodule

bind paged_decay_trend_zscore_diff pdtz_chk u_pdtz_chk (.*);
